/* hw/rtl/rti_pkg.sv */
package rti_pkg;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned POS_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SUM_W = 18;
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd2;

  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_XRGB8888 = 1'b1;

  localparam logic [DIM_W-1:0] LINE_WIDTH_RESET = 13'd240;
  localparam logic [DIM_W-1:0] LINE_COUNT_RESET = 13'd160;

  localparam logic signed [SUM_W-1:0] Y_R = 18'sd66;
  localparam logic signed [SUM_W-1:0] Y_G = 18'sd129;
  localparam logic signed [SUM_W-1:0] Y_B = 18'sd25;
  localparam logic signed [SUM_W-1:0] CB_R = -18'sd38;
  localparam logic signed [SUM_W-1:0] CB_G = -18'sd74;
  localparam logic signed [SUM_W-1:0] CB_B = 18'sd112;
  localparam logic signed [SUM_W-1:0] CR_R = 18'sd112;
  localparam logic signed [SUM_W-1:0] CR_G = -18'sd94;
  localparam logic signed [SUM_W-1:0] CR_B = -18'sd18;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = 18'sd128;
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET = 18'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 18'sd128;

  function automatic logic [CHAN_W-1:0] finish_sample(
    input logic signed [SUM_W-1:0] sum,
    input logic signed [SUM_W-1:0] offset
  );
    logic signed [SUM_W-1:0] q;
    q = (sum >>> 8) + offset;
    if (q < 0) begin
      return '0;
    end else if (q > 18'sd255) begin
      return '1;
    end
    return q[CHAN_W-1:0];
  endfunction

endpackage

/* hw/rtl/rgb_to_i420_converter.sv */
// RGB to I420 pixel converter.
// Pixels enter in raster order on the in_ channel, one item per pixel, and
// each yields one item on the out_ channel: its luma, its column and row, a
// frame end flag, and at even columns of even rows a Cb/Cr pair taken from
// that pixel alone. Both channels move an item at a clock edge with valid
// high and stall low.
// The cfg_ channel writes pixel_format, line_width and line_count; it is
// always ready and is meant to be written only while no item is in flight.
// An accepted item passes through the middle stage and then into the output
// register, where its result can be taken. One item can be accepted every
// cycle while in_stall is low; the throughput is one pixel per clock, set by
// the two register stages that each hold one item.
// When the receiver stalls, the output item holds, the middle stage fills,
// and then in_stall rises in the same cycle until the output frees up.
// Synchronous reset (rst_n low) empties both stages, restores the register
// defaults (RGB565, 240 by 160) and sets the column and row counters to 0.
module rgb_to_i420_converter #(
  parameter int unsigned MAX_DIM = rti_pkg::MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rti_pkg::PIXEL_W-1:0]      in_pixel_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rti_pkg::CHAN_W-1:0]       out_luma,
  output logic                             out_chroma_valid,
  output logic [rti_pkg::CHAN_W-1:0]       out_cb_value,
  output logic [rti_pkg::CHAN_W-1:0]       out_cr_value,
  output logic [rti_pkg::POS_W-1:0]        out_column,
  output logic [rti_pkg::POS_W-1:0]        out_row,
  output logic                             out_frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rti_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rti_pkg::*;

  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'((MAX_DIM < 8191) ? MAX_DIM : 8191);

  logic              pixel_format_r;
  logic [DIM_W-1:0]  line_width_r;
  logic [DIM_W-1:0]  line_count_r;
  logic [POS_W-1:0]  col_r;
  logic [POS_W-1:0]  row_r;
  logic [POS_W-1:0]  col_nxt;
  logic [POS_W-1:0]  row_nxt;

  logic              s1_valid_r;
  logic [CHAN_W-1:0] s1_red_r;
  logic [CHAN_W-1:0] s1_green_r;
  logic [CHAN_W-1:0] s1_blue_r;
  logic [POS_W-1:0]  s1_col_r;
  logic [POS_W-1:0]  s1_row_r;
  logic              s1_chroma_r;
  logic              s1_frame_end_r;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_luma_r;
  logic              out_chroma_r;
  logic [CHAN_W-1:0] out_cb_r;
  logic [CHAN_W-1:0] out_cr_r;
  logic [POS_W-1:0]  out_col_r;
  logic [POS_W-1:0]  out_row_r;
  logic              out_frame_end_r;

  logic              out_en;
  logic              s1_en;
  logic              in_accept;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [DIM_W-1:0]  width_sat;
  logic [DIM_W-1:0]  height_sat;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  row_inc;
  logic              last_col;
  logic              last_row;

  logic signed [SUM_W-1:0] red_s;
  logic signed [SUM_W-1:0] green_s;
  logic signed [SUM_W-1:0] blue_s;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] cb_sum;
  logic signed [SUM_W-1:0] cr_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_RGB565;
      line_width_r <= LINE_WIDTH_RESET;
      line_count_r <= LINE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format_r <= cfg_data[0];
        REG_LINE_WIDTH:   line_width_r <= cfg_data;
        REG_LINE_COUNT:   line_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_en = !out_valid_r || !out_stall;
  assign s1_en = !s1_valid_r || out_en;
  assign in_stall = !s1_en;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (pixel_format_r == FMT_XRGB8888) begin
      red = in_pixel_word[23:16];
      green = in_pixel_word[15:8];
      blue = in_pixel_word[7:0];
    end else begin
      red = {in_pixel_word[15:11], 3'b000};
      green = {in_pixel_word[10:5], 2'b00};
      blue = {in_pixel_word[4:0], 3'b000};
    end
  end

  always_comb begin
    if (line_width_r == '0) begin
      width_sat = DIM_W'(1);
    end else if (line_width_r > DIM_CAP) begin
      width_sat = DIM_CAP;
    end else begin
      width_sat = line_width_r;
    end
    if (line_count_r == '0) begin
      height_sat = DIM_W'(1);
    end else if (line_count_r > DIM_CAP) begin
      height_sat = DIM_CAP;
    end else begin
      height_sat = line_count_r;
    end
    col_inc = {1'b0, col_r} + DIM_W'(1);
    row_inc = {1'b0, row_r} + DIM_W'(1);
    last_col = col_inc >= width_sat;
    last_row = row_inc >= height_sat;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_nxt = col_inc[POS_W-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_red_r <= red;
      s1_green_r <= green;
      s1_blue_r <= blue;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_chroma_r <= !col_r[0] && !row_r[0];
      s1_frame_end_r <= last_col && last_row;
    end
  end

  always_comb begin
    red_s = $signed({{(SUM_W-CHAN_W){1'b0}}, s1_red_r});
    green_s = $signed({{(SUM_W-CHAN_W){1'b0}}, s1_green_r});
    blue_s = $signed({{(SUM_W-CHAN_W){1'b0}}, s1_blue_r});
    y_sum = Y_R * red_s + Y_G * green_s + Y_B * blue_s + ROUND_BIAS;
    cb_sum = CB_R * red_s + CB_G * green_s + CB_B * blue_s + ROUND_BIAS;
    cr_sum = CR_R * red_s + CR_G * green_s + CR_B * blue_s + ROUND_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_luma_r <= finish_sample(y_sum, LUMA_OFFSET);
      out_chroma_r <= s1_chroma_r;
      out_cb_r <= s1_chroma_r ? finish_sample(cb_sum, CHROMA_OFFSET) : '0;
      out_cr_r <= s1_chroma_r ? finish_sample(cr_sum, CHROMA_OFFSET) : '0;
      out_col_r <= s1_col_r;
      out_row_r <= s1_row_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_luma = out_luma_r;
  assign out_chroma_valid = out_chroma_r;
  assign out_cb_value = out_cb_r;
  assign out_cr_value = out_cr_r;
  assign out_column = out_col_r;
  assign out_row = out_row_r;
  assign out_frame_end = out_frame_end_r;

  // Chroma appears only on even columns of even rows, and is zero elsewhere.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chroma_valid |-> !out_column[0] && !out_row[0])
    else $error("chroma given at an odd position");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chroma_valid |-> out_cb_value == '0 && out_cr_value == '0)
    else $error("chroma not cleared without chroma_valid");

  // The pixel that ends a frame sends both counters back to the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && last_col && last_row |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap at frame end");

  // A middle-stage item that cannot move on is kept.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_en |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_row_r))
    else $error("middle-stage item lost under stall");

endmodule
